>>> src/b85d_pkg.sv
// Package for the base85 identifier decoder: payload types, the digit table
// and the constant place weights. No dependencies.
package b85d_pkg;

  // Characters in one group, and the position of the last digit of a group
  localparam int unsigned GROUP_LEN = 5;
  localparam logic [2:0] LAST_DIGIT = 3'(GROUP_LEN - 1);

  // Table entry for a character outside the alphabet
  localparam logic [7:0] UNMAPPED = 8'hff;

  // Depth of the internal queues
  localparam int unsigned QUEUE_DEPTH = 2;

  // Status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        start_req;
  } in_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  word_index;
    logic        status;
    logic        last;
  } result_t;

  // Classified character handed from the front to the back
  typedef struct packed {
    logic [6:0] digit;
    logic [2:0] digit_pos;
    logic [1:0] word_index;
    logic       last_word;
    logic       bad;
  } digit_item_t;

  localparam logic [7:0] DIGIT_TABLE [128] = '{
    8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
    8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
    8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
    8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
    8'hff,8'h00,8'hff,8'hff,8'h01,8'h02,8'h03,8'h04,
    8'h05,8'h06,8'h07,8'h08,8'h09,8'h0a,8'h0b,8'hff,
    8'h0c,8'h0d,8'h0e,8'h0f,8'h10,8'h11,8'h12,8'h13,
    8'h14,8'h15,8'hff,8'hff,8'hff,8'h16,8'hff,8'h17,
    8'h18,8'h19,8'h1a,8'h1b,8'h1c,8'h1d,8'h1e,8'h1f,
    8'h20,8'h21,8'h22,8'h23,8'h24,8'h25,8'h26,8'h27,
    8'h28,8'h29,8'h2a,8'h2b,8'h2c,8'h2d,8'h2e,8'h2f,
    8'h30,8'h31,8'h32,8'h33,8'hff,8'h34,8'h35,8'h36,
    8'h37,8'h38,8'h39,8'h3a,8'h3b,8'h3c,8'h3d,8'h3e,
    8'h3f,8'h40,8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,
    8'h47,8'h48,8'h49,8'h4a,8'h4b,8'h4c,8'h4d,8'h4e,
    8'h4f,8'h50,8'h51,8'h52,8'hff,8'h53,8'h54,8'hff
  };

  // Weight of a digit by its place in the group, least significant first
  function automatic logic [31:0] place_weight(input logic [2:0] pos);
    logic [31:0] w;
    case (pos)
      3'd0:    w = 32'd1;
      3'd1:    w = 32'd85;
      3'd2:    w = 32'd7225;
      3'd3:    w = 32'd614125;
      3'd4:    w = 32'd52200625;
      default: w = 32'd0;
    endcase
    return w;
  endfunction

endpackage

>>> src/b85d_fifo.sv
// Small register queue used between the decoder stages and at the output.
// Depends on nothing.
module b85d_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    rd_ptr;
  logic [PW-1:0]    wr_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Store the request at the write pointer
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> src/b85d_front.sv
// Front stage: looks each character up in the digit table and tracks its
// place in the identifier. Depends on b85d_pkg.
module b85d_front #(
  parameter int unsigned NUM_WORDS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  b85d_pkg::in_item_t    item,
  output b85d_pkg::digit_item_t classified
);

  localparam int unsigned WW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  logic [2:0]    digit_pos;
  logic [2:0]    digit_pos_next;
  logic [WW-1:0] word_no;
  logic [WW-1:0] word_no_next;
  logic [2:0]    cur_pos;
  logic [WW-1:0] cur_word;
  logic [WW+1:0] word_wide;
  logic [7:0]    entry;
  logic          bad;

  function automatic logic [7:0] DIGIT_LOOKUP(input logic [6:0] cu);
    return b85d_pkg::DIGIT_TABLE[cu];
  endfunction

  // Restart the position on a start request
  assign cur_pos   = item.start_req ? 3'd0 : digit_pos;
  assign cur_word  = item.start_req ? '0 : word_no;
  assign word_wide = {2'b00, cur_word};

  // Flag a character beyond 7 bits or one the table leaves unmapped
  assign entry = DIGIT_LOOKUP(item.code_unit[6:0]);
  assign bad   = (item.code_unit[15:7] != 9'd0) || (entry == b85d_pkg::UNMAPPED);

  always_comb begin
    classified.digit      = entry[6:0];
    classified.digit_pos  = cur_pos;
    classified.word_index = word_wide[1:0];
    classified.last_word  = (cur_word == WW'(NUM_WORDS - 1));
    classified.bad        = bad;
  end

  // Step to the next character, wrapping at the end of the identifier; restart on a bad one
  always_comb begin
    digit_pos_next = cur_pos + 3'd1;
    word_no_next   = cur_word;
    if (bad) begin
      digit_pos_next = 3'd0;
      word_no_next   = '0;
    end else if (cur_pos == b85d_pkg::LAST_DIGIT) begin
      digit_pos_next = 3'd0;
      word_no_next   = (cur_word == WW'(NUM_WORDS - 1)) ? '0 : cur_word + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_pos <= 3'd0;
      word_no   <= '0;
    end else if (accept) begin
      digit_pos <= digit_pos_next;
      word_no   <= word_no_next;
    end
  end

endmodule

>>> src/b85d_back.sv
// Back stage: accumulates weighted digits into a word and forms results.
// Depends on b85d_pkg.
module b85d_back (
  input  logic                  clk,
  input  logic                  take,
  input  b85d_pkg::digit_item_t classified,
  output logic                  emit,
  output b85d_pkg::result_t     result
);

  logic [31:0] acc;
  logic [31:0] acc_next;
  logic [31:0] base;
  logic [31:0] product;

  // Clear at a group start, then add digit times its place weight
  assign base     = (classified.digit_pos == 3'd0) ? 32'd0 : acc;
  assign product  = {25'd0, classified.digit} *
                    b85d_pkg::place_weight(classified.digit_pos);
  assign acc_next = base + product;

  always_ff @(posedge clk) begin
    if (take && !classified.bad) begin
      acc <= acc_next;
    end
  end

  // Emit on a bad character or at the last digit of a group
  always_comb begin
    emit = take && (classified.bad || (classified.digit_pos == b85d_pkg::LAST_DIGIT));
    result.word_index = classified.word_index;
    if (classified.bad) begin
      result.word   = 32'd0;
      result.status = b85d_pkg::STATUS_BAD;
      result.last   = 1'b1;
    end else begin
      result.word   = acc_next;
      result.status = b85d_pkg::STATUS_OK;
      result.last   = classified.last_word;
    end
  end

endmodule

>>> src/base85_id_decoder_unit.sv
// Base85 identifier decoder, one 16-bit character per cycle while not full.
// A result forms in the back from its fifth (or a bad) character taken from the
// middle queue, and is registered in the output queue until it is popped.
// Throughput: one character per cycle while neither queue backs up, set by the
// table lookup in the front and the multiply-accumulate in the back.
// Reset (rst, synchronous): empties both queues and returns the position to
// the start of an identifier.
module base85_id_decoder_unit #(
  parameter int unsigned NUM_WORDS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  b85d_pkg::in_item_t  item,
  input  logic                pop,
  output logic                empty,
  output b85d_pkg::result_t   result
);

  localparam int unsigned DW = $bits(b85d_pkg::digit_item_t);
  localparam int unsigned RW = $bits(b85d_pkg::result_t);

  b85d_pkg::digit_item_t classified;
  b85d_pkg::digit_item_t queued;
  b85d_pkg::result_t     back_result;
  logic                  accept;
  logic                  mid_full;
  logic                  mid_empty;
  logic                  out_full;
  logic                  take;
  logic                  emit;
  logic [DW-1:0]         queued_bits;
  logic [RW-1:0]         result_bits;

  assign full   = mid_full;
  assign accept = push && !mid_full;

  // Classify incoming characters
  b85d_front #(
    .NUM_WORDS (NUM_WORDS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (item),
    .classified (classified)
  );

  // Decouple front and back
  b85d_fifo #(
    .WIDTH (DW),
    .DEPTH (b85d_pkg::QUEUE_DEPTH)
  ) u_mid_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .wdata (classified),
    .full  (mid_full),
    .pop   (take),
    .rdata (queued_bits),
    .empty (mid_empty)
  );

  assign queued = b85d_pkg::digit_item_t'(queued_bits);

  // Hold the back while the output queue has no room
  assign take = !mid_empty && !out_full;

  b85d_back u_back (
    .clk        (clk),
    .take       (take),
    .classified (queued),
    .emit       (emit),
    .result     (back_result)
  );

  // Keep finished results until they are taken
  b85d_fifo #(
    .WIDTH (RW),
    .DEPTH (b85d_pkg::QUEUE_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (emit),
    .wdata (back_result),
    .full  (out_full),
    .pop   (pop),
    .rdata (result_bits),
    .empty (empty)
  );

  assign result = b85d_pkg::result_t'(result_bits);

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for base85_id_decoder_unit: directed and random
// character streams against an in-bench predictor of the decoder.
// Depends on b85d_pkg (payload types, status codes) and the decoder RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned ID_WORDS       = 4;
  localparam int unsigned CHARS_PER_WORD = 5;
  localparam int unsigned ID_CHARS       = ID_WORDS * CHARS_PER_WORD;
  localparam logic [7:0]  NO_DIGIT       = 8'hff;
  localparam int unsigned RANDOM_CHARS   = 750;
  localparam int unsigned MAX_GAP        = 18;
  localparam int unsigned HOLD_AT        = 320;
  localparam int unsigned HOLD_CYCLES    = 150;
  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned DRAIN_CYCLES   = 12;
  localparam int unsigned MAX_PRINTED    = 100;

  // One pending request: the character and the idle cycles before it
  typedef struct {
    b85d_pkg::in_item_t req;
    int unsigned        gap;
  } pending_char_t;

  logic               clk  = 1'b0;
  logic               rst  = 1'b1;
  logic               push = 1'b0;
  logic               pop  = 1'b0;
  b85d_pkg::in_item_t item = '0;
  logic               full;
  logic               empty;
  b85d_pkg::result_t  result;

  pending_char_t     char_q[$];
  b85d_pkg::result_t word_q[$];
  logic [15:0]       digit_char[85];

  // Predictor state
  int unsigned id_pos;
  logic [31:0] word_acc;
  logic [31:0] digit_weight;

  int unsigned chars_taken = 0;
  int unsigned words_taken = 0;
  int unsigned bad_expected = 0;
  int unsigned ids_closed = 0;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  int unsigned gen_count = 0;
  logic        tx_fast = 1'b0;
  logic        rx_fast = 1'b0;
  int unsigned tx_wait;
  int unsigned rx_wait;
  int unsigned rx_gap;
  pending_char_t next_char;

  base85_id_decoder_unit #(
    .NUM_WORDS(ID_WORDS)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .item  (item),
    .pop   (pop),
    .empty (empty),
    .result(result)
  );

  always #2 clk = ~clk;

  // Map a character to its digit in this alphabet, least significant first
  function automatic logic [7:0] char_digit(input logic [15:0] c);
    logic [7:0] d;
    d = NO_DIGIT;
    if (c == 16'h21) d = 8'd0;
    else if (c >= 16'h24 && c <= 16'h2e) d = 8'(c - 16'h24 + 16'd1);
    else if (c >= 16'h30 && c <= 16'h39) d = 8'(c - 16'h30 + 16'd12);
    else if (c == 16'h3d) d = 8'd22;
    else if (c >= 16'h3f && c <= 16'h5b) d = 8'(c - 16'h3f + 16'd23);
    else if (c >= 16'h5d && c <= 16'h7b) d = 8'(c - 16'h5d + 16'd52);
    else if (c == 16'h7d || c == 16'h7e) d = 8'(c - 16'h7d + 16'd83);
    return d;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Advance the predictor by one accepted character; queue any word it yields
  task automatic predict_char(input b85d_pkg::in_item_t rq);
    logic [7:0]        d;
    int unsigned       dpos;
    int unsigned       wno;
    b85d_pkg::result_t r;
    if (rq.start_req || id_pos >= ID_CHARS) id_pos = 0;
    dpos = id_pos % CHARS_PER_WORD;
    wno  = id_pos / CHARS_PER_WORD;
    if (dpos == 0) begin
      word_acc     = '0;
      digit_weight = 32'd1;
    end
    d = char_digit(rq.code_unit);
    if (d == NO_DIGIT) begin
      r.word       = '0;
      r.word_index = 2'(wno);
      r.status     = b85d_pkg::STATUS_BAD;
      r.last       = 1'b1;
      word_q.push_back(r);
      bad_expected++;
      id_pos       = 0;
      word_acc     = '0;
      digit_weight = 32'd1;
    end else begin
      word_acc     = word_acc + {24'd0, d} * digit_weight;
      digit_weight = digit_weight * 32'd85;
      id_pos++;
      if (id_pos >= ID_CHARS) id_pos = 0;
      if (dpos == CHARS_PER_WORD - 1) begin
        r.word       = word_acc;
        r.word_index = 2'(wno);
        r.status     = b85d_pkg::STATUS_OK;
        r.last       = (wno == ID_WORDS - 1);
        word_q.push_back(r);
      end
    end
  endtask

  // Compare one popped result with the oldest expected word
  task automatic check_word(input b85d_pkg::result_t got);
    b85d_pkg::result_t want;
    if (word_q.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected: %h", got));
    end else begin
      want = word_q.pop_front();
      if (got.word !== want.word)
        report_mismatch($sformatf("word %h, expected %h", got.word, want.word));
      if (got.word_index !== want.word_index)
        report_mismatch($sformatf("word_index %0d, expected %0d",
                                  got.word_index, want.word_index));
      if (got.status !== want.status)
        report_mismatch($sformatf("status %b, expected %b", got.status, want.status));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
      if (want.last && want.status == b85d_pkg::STATUS_OK) ids_closed++;
    end
  endtask

  // Queue one character; gaps vanish inside the window where the block is to fill up
  task automatic add_char(input logic [15:0] code, input logic start);
    pending_char_t pc;
    if ($urandom_range(0, 29) == 0) tx_fast = !tx_fast;
    pc.req.code_unit = code;
    pc.req.start_req = start;
    if (gen_count + 10 >= HOLD_AT && gen_count < HOLD_AT + 200) pc.gap = 0;
    else pc.gap = tx_fast ? 0 : $urandom_range(0, MAX_GAP);
    char_q.push_back(pc);
    gen_count++;
  endtask

  function automatic logic [15:0] any_digit_char();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return digit_char[0];
    if (pick == 1) return digit_char[84];
    return digit_char[$urandom_range(0, 84)];
  endfunction

  function automatic logic [15:0] any_bad_char();
    logic [15:0] c;
    if ($urandom_range(0, 1) == 0) begin
      c = 16'($urandom_range(16'h80, 16'hffff));
    end else begin
      c = 16'($urandom_range(0, 127));
      while (char_digit(c) != NO_DIGIT) c = 16'($urandom_range(0, 127));
    end
    return c;
  endfunction

  // Sender: offer the next pending request once its gap has run out
  always @(posedge clk) begin
    if (rst) begin
      push    <= 1'b0;
      tx_wait = 0;
    end else begin
      if (push && !full) begin
        predict_char(item);
        chars_taken <= chars_taken + 1;
      end
      if (!push || !full) begin
        if (char_q.size() == 0) begin
          push <= 1'b0;
        end else if (tx_wait < char_q[0].gap) begin
          tx_wait++;
          push <= 1'b0;
        end else begin
          next_char = char_q.pop_front();
          item <= next_char.req;
          push <= 1'b1;
          tx_wait = 0;
        end
      end
    end
  end

  // Receiver: check each popped word, then wait a drawn number of cycles
  always @(posedge clk) begin
    if (rst) begin
      pop    <= 1'b0;
      rx_wait = 0;
      rx_gap  = 0;
    end else begin
      if ($urandom_range(0, 39) == 0) rx_fast = !rx_fast;
      if (pop && !empty) begin
        check_word(result);
        words_taken <= words_taken + 1;
        rx_gap  = rx_fast ? 0 : $urandom_range(0, MAX_GAP);
        rx_wait = 0;
      end
      if (hold_left != 0) begin
        pop <= 1'b0;
      end else if (rx_wait < rx_gap) begin
        rx_wait++;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Hold off the receiver once, long enough for the block to back up
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && chars_taken >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Count cycles in which no request moves on either side
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
    $display("base85_id_decoder_unit regression: fail");
    $finish;
  end

  initial begin
    int unsigned kind;
    int unsigned n;
    id_pos       = 0;
    word_acc     = '0;
    digit_weight = 32'd1;
    for (int c = 0; c < 128; c++)
      if (char_digit(16'(c)) != NO_DIGIT) digit_char[char_digit(16'(c))] = 16'(c);

    // Directed: largest and smallest word, bad characters of each kind,
    // a bad character mid-group and a forced restart mid-group
    for (int k = 0; k < 5; k++) add_char(digit_char[84], k == 0);
    for (int k = 0; k < 5; k++) add_char(digit_char[0], k == 0);
    add_char(digit_char[1], 1'b1);
    add_char(digit_char[83], 1'b0);
    add_char(16'hffff, 1'b0);
    add_char(16'h0080, 1'b1);
    add_char(16'h007f, 1'b0);
    add_char(16'h005c, 1'b0);
    add_char(16'h007c, 1'b0);
    add_char(16'h0000, 1'b0);
    add_char(16'h0039, 1'b0);
    add_char(16'h0040, 1'b0);
    for (int k = 0; k < 5; k++) add_char(digit_char[84 - k], k == 0);

    // Random: mostly whole identifiers, some broken ones, some raw noise
    n = gen_count + RANDOM_CHARS;
    while (gen_count < n) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        for (int k = 0; k < ID_CHARS; k++)
          add_char(any_digit_char(), k == 0 ? 1'($urandom_range(0, 1)) : 1'b0);
      end else if (kind < 9) begin
        for (int k = $urandom_range(1, ID_CHARS - 1); k > 0; k--)
          add_char(any_digit_char(), 1'b0);
        if (kind == 7) add_char(any_bad_char(), 1'($urandom_range(0, 1)));
        else add_char(any_digit_char(), 1'b1);
      end else begin
        for (int k = $urandom_range(1, 6); k > 0; k--)
          add_char(16'($urandom_range(0, 16'hffff)), 1'($urandom_range(0, 1)));
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Drain: everything sent, everything expected has arrived
    while (char_q.size() != 0 || push || word_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d characters; checked %0d results", chars_taken, words_taken);
    $display("%0d complete identifiers, %0d errors; receiver held off %0d cycles mid-run",
             ids_closed, bad_expected, HOLD_CYCLES);
    if (mismatches == 0 && word_q.size() == 0) begin
      $display("base85_id_decoder_unit regression: pass");
    end else begin
      $display("base85_id_decoder_unit regression: fail");
    end
    $finish;
  end

endmodule

>>> base85_id_decoder_unit.f
src/b85d_pkg.sv
src/b85d_fifo.sv
src/b85d_front.sv
src/b85d_back.sv
src/base85_id_decoder_unit.sv
tb/tb_top.sv
